// ----- design/tep_pkg.sv -----
// shared types and constants for the tree ensemble predictor
package tep_pkg;

  typedef enum logic [1:0] {
    OP_NODE    = 2'd0,
    OP_FEATURE = 2'd1,
    OP_PREDICT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  localparam logic [0:0] REG_NODES = 1'b0;
  localparam logic [0:0] REG_TREES = 1'b1;

  // table sizes follow the fixed field widths of the command word
  localparam int unsigned NODES     = 4096;
  localparam int unsigned FEATURES  = 64;
  // fraction position does not change the mean; it only names the format
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CFG_NODES_W = 13;
  localparam int unsigned CFG_TREES_W = 12;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned VAR_W       = 16;
  localparam int unsigned FIDX_W      = 6;
  localparam int unsigned SUM_W       = 44;

endpackage

// ----- design/tep_div.sv -----
// restoring divider for the mean, one quotient bit per cycle
module tep_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [tep_pkg::SUM_W-1:0] dividend_i,
  input  logic [tep_pkg::CFG_TREES_W-1:0]   divisor_i,
  output logic                       done_o,
  output logic signed [tep_pkg::VALUE_W-1:0] quot_o
);
  import tep_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  num_q, num_d;
  logic [SUM_W:0]    rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    shifted;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  qs;

  assign mag     = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
  assign shifted = {rem_q[SUM_W-1:0], num_q[SUM_W-1]};
  assign trial   = shifted - (SUM_W+1)'(divisor_i);
  assign qs      = neg_q ? SUM_W'(-num_q) : num_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W);
      num_d  = mag;
      rem_d  = '0;
      neg_d  = dividend_i[SUM_W-1];
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (!trial[SUM_W]) begin
          rem_d = trial;
          num_d = {num_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = shifted;
          num_d = {num_q[SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = qs[VALUE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end
endmodule

// ----- design/tree_ensemble_predict.sv -----
// tree ensemble predictor top level: node table, feature store, walk sequencer
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  command   | opcode_i ... feature_value_i            | start_i high, busy_o low
//  result    | prediction_o ... walk_error_o           | done_o strobe, one cycle
//  config    | psel_i penable_i pwrite_i paddr_i ...   | apb, pready_o always high
//
// a load word is written when it is accepted. a predict word scans entries one by one for a
// tree start, then walks each tree: an inner node takes a node read, then a feature read, and
// a leaf takes a node read; then the divider runs when a tree counted and no walk failed;
// the result strobe is registered in the cycle after that. the node table port sets the rate.
// reset clears control and sets config to its defaults; memories hold garbage until written.
// the receiver cannot stall: done_o is high for one cycle only.
module tree_ensemble_predict (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [1:0]                             opcode_i,
  input  logic [tep_pkg::ADDR_W-1:0]             node_address_i,
  input  logic signed [tep_pkg::VALUE_W-1:0]     split_value_i,
  input  logic [tep_pkg::ADDR_W-1:0]             right_child_i,
  input  logic [tep_pkg::VAR_W-1:0]              var_or_count_i,
  input  logic [tep_pkg::FIDX_W-1:0]             feature_index_i,
  input  logic signed [tep_pkg::VALUE_W-1:0]     feature_value_i,
  output logic                                   done_o,
  output logic signed [tep_pkg::VALUE_W-1:0]     prediction_o,
  output logic [tep_pkg::CFG_TREES_W-1:0]        trees_counted_o,
  output logic                                   no_trees_o,
  output logic                                   walk_error_o,
  input  logic                                   psel_i,
  input  logic                                   penable_i,
  input  logic                                   pwrite_i,
  input  logic [2:0]                             paddr_i,
  input  logic [31:0]                            pwdata_i,
  output logic [31:0]                            prdata_o,
  output logic                                   pready_o
);
  import tep_pkg::*;

  localparam int unsigned NA_W = $clog2(NODES);
  localparam int unsigned FA_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int unsigned NE_W = VALUE_W + ADDR_W + VAR_W;
  localparam int unsigned K_W  = NA_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_WAITF = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  // memories
  logic [NE_W-1:0]    node_mem [NODES];
  logic [VALUE_W-1:0] feat_mem [FEATURES];
  logic [NE_W-1:0]    node_rd_q;
  logic [VALUE_W-1:0] feat_rd_q;

  logic [CFG_NODES_W-1:0] nodes_cfg_q;
  logic [CFG_TREES_W-1:0] trees_cfg_q;

  logic [2:0]             state_q, state_d;
  logic [K_W-1:0]         k_q, k_d;
  logic [K_W-1:0]         visits_q, visits_d;
  logic [CFG_TREES_W-1:0] count_q, count_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                   err_q, err_d;
  logic                   walk_q, walk_d;
  logic                   rd_en;
  logic [NA_W-1:0]        rd_addr;
  logic                   frd_en;
  logic [FA_W-1:0]        frd_addr;
  logic                   div_start;
  logic                   div_done;
  logic signed [VALUE_W-1:0] div_quot;
  logic [K_W:0]           n_eff;
  logic signed [VALUE_W-1:0] rd_split;
  logic [ADDR_W-1:0]      rd_right;
  logic [VAR_W-1:0]       rd_var;
  logic signed [VALUE_W-1:0] thr_q;
  logic [ADDR_W-1:0]      rch_q;
  logic                   res_v_q;
  logic signed [VALUE_W-1:0] res_pred_q;
  logic [CFG_TREES_W-1:0] res_cnt_q;
  logic                   res_err_q;
  logic                   cfg_wr;
  logic                   accept;
  logic                   node_we;
  logic                   feat_we;

  assign n_eff = (K_W+1)'((32'(nodes_cfg_q) > NODES) ? NODES : 32'(nodes_cfg_q));
  assign {rd_split, rd_right, rd_var} = node_rd_q;

  assign accept  = start_i && (state_q == S_IDLE);
  assign busy_o  = (state_q != S_IDLE);
  assign node_we = accept && (opcode_i == OP_NODE) && (32'(node_address_i) < NODES);
  assign feat_we = accept && (opcode_i == OP_FEATURE) && (32'(feature_index_i) < FEATURES);

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_address_i[NA_W-1:0]] <= {split_value_i, right_child_i, var_or_count_i};
    end
    if (rd_en) begin
      node_rd_q <= node_mem[rd_addr];
    end
    if (feat_we) begin
      feat_mem[feature_index_i[FA_W-1:0]] <= feature_value_i;
    end
    if (frd_en) begin
      feat_rd_q <= feat_mem[frd_addr];
    end
  end

  // config port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == REG_TREES) prdata_o = 32'(trees_cfg_q);
    else                         prdata_o = 32'(nodes_cfg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_cfg_q <= CFG_NODES_W'(4096);
      trees_cfg_q <= CFG_TREES_W'(1);
    end else if (cfg_wr) begin
      if (paddr_i[2] == REG_NODES) nodes_cfg_q <= pwdata_i[CFG_NODES_W-1:0];
      else                         trees_cfg_q <= pwdata_i[CFG_TREES_W-1:0];
    end
  end

  // walk sequencer: k_q is the entry being read; walk_q marks the divider as started
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    visits_d  = visits_q;
    count_d   = count_q;
    sum_d     = sum_q;
    err_d     = err_q;
    walk_d    = walk_q;
    rd_en     = 1'b0;
    rd_addr   = k_q[NA_W-1:0];
    frd_en    = 1'b0;
    frd_addr  = rd_var[FA_W-1:0];
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && opcode_i == OP_PREDICT) begin
          k_d     = '0;
          count_d = '0;
          sum_d   = '0;
          err_d   = 1'b0;
          walk_d  = 1'b0;
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // node_rd_q holds entry k_q when arriving here from a read
        if ((K_W+1)'(k_q) >= n_eff) begin
          state_d = S_DIV;
        end else if (rd_right == '0 && rd_var == '0) begin
          if (count_q >= trees_cfg_q) begin
            state_d = S_DIV;
          end else begin
            k_d      = k_q + 1'b1;
            visits_d = '0;
            rd_en    = 1'b1;
            rd_addr  = NA_W'(k_q + 1'b1);
            state_d  = S_WALK;
            if ((K_W+1)'(k_q + 1'b1) >= n_eff) begin
              err_d   = 1'b1;
              state_d = S_DIV;
            end
          end
        end else begin
          k_d     = k_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = NA_W'(k_q + 1'b1);
        end
      end
      S_WALK: begin
        if ((K_W+1)'(visits_q) >= n_eff) begin
          err_d   = 1'b1;
          state_d = S_DIV;
        end else begin
          visits_d = visits_q + 1'b1;
          if (rd_right != '0) begin
            if (32'(rd_var) >= FEATURES) begin
              err_d   = 1'b1;
              state_d = S_DIV;
            end else begin
              frd_en  = 1'b1;
              state_d = S_WAITF;
            end
          end else begin
            count_d = count_q + 1'b1;
            sum_d   = sum_q + SUM_W'(rd_split);
            k_d     = k_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = NA_W'(k_q + 1'b1);
            state_d = S_SCAN;
          end
        end
      end
      S_WAITF: begin
        if ($signed(feat_rd_q) >= thr_q) k_d = k_q + 1'b1;
        else                             k_d = K_W'(rch_q);
        rd_en   = 1'b1;
        rd_addr = NA_W'(k_d);
        state_d = S_WALK;
        if ((K_W+1)'(k_d) >= n_eff) begin
          err_d   = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!walk_q) begin
          walk_d    = 1'b1;
          div_start = !err_q && count_q != '0;
          if (err_q || count_q == '0) begin
            state_d = S_IDLE;
            walk_d  = 1'b0;
          end
        end else if (div_done) begin
          state_d = S_IDLE;
          walk_d  = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  tep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      walk_q   <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      res_v_q  <= (state_q == S_DIV) && (state_d == S_IDLE);
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    visits_q <= visits_d;
    count_q  <= count_d;
    sum_q    <= sum_d;
    err_q    <= err_d;
    thr_q    <= rd_split;
    rch_q    <= rd_right;
    if (state_q == S_DIV && state_d == S_IDLE) begin
      res_pred_q <= (walk_q && div_done) ? div_quot : '0;
      res_cnt_q  <= count_q;
      res_err_q  <= err_q;
    end
  end

  assign done_o          = res_v_q;
  assign prediction_o    = res_pred_q;
  assign trees_counted_o = res_cnt_q;
  assign no_trees_o      = (res_cnt_q == '0);
  assign walk_error_o    = res_err_q;
endmodule
